### hw/rtl/tsfp_pkg.sv
// ----------------------------------------------------------------------------
// tsfp_pkg
// Types and constants shared by the TLV settings field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfp_pkg;

	// Tag ranges of the known fields
	localparam logic [7:0] TAG_BYTE_LO = 8'h01;
	localparam logic [7:0] TAG_BYTE_HI = 8'h04;
	localparam logic [7:0] TAG_WORD_LO = 8'h05;
	localparam logic [7:0] TAG_WORD_HI = 8'h08;

	// Lengths that the known fields must state
	localparam logic [7:0] LEN_BYTE = 8'd1;
	localparam logic [7:0] LEN_WORD = 8'd2;

	typedef enum logic [1:0] {
		PH_TAG = 2'd0,
		PH_LEN = 2'd1,
		PH_VAL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  setting_index;
		logic [15:0] setting_value;
	} out_beat_t;

	// Result of the parse stage towards the result register
	typedef struct packed {
		logic      valid;
		out_beat_t beat;
	} parse_res_t;

	// Status of the parse stage
	typedef struct packed {
		logic stage_valid;
		logic step;
	} parse_stat_t;

	function automatic logic field_is_valid(input logic [7:0] tag, input logic [7:0] len);
		logic res;
		res = 1'b0;
		if (tag >= TAG_BYTE_LO && tag <= TAG_BYTE_HI) begin
			res = (len == LEN_BYTE);
		end else if (tag >= TAG_WORD_LO && tag <= TAG_WORD_HI) begin
			res = (len == LEN_WORD);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tsfp_stream_if.sv
// ----------------------------------------------------------------------------
// tsfp_stream_if
// Valid/ready stream channel carrying one beat of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsfp_stream_if #(
	parameter type beat_t = tsfp_pkg::in_beat_t
);
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/tsfp_parse.sv
// ----------------------------------------------------------------------------
// tsfp_parse
// Input register, field parse state and result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfp_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	tsfp_stream_if.sink           payload,
	input  wire logic             free,
	output tsfp_pkg::parse_res_t  res,
	output tsfp_pkg::parse_stat_t stat
);

	logic               valid_s1;
	tsfp_pkg::in_beat_t data_s1;
	logic               step;
	logic               accept;

	tsfp_pkg::phase_t phase_q, phase_d;
	logic [7:0]       tag_q, tag_d;
	logic [7:0]       rem_q, rem_d;
	logic             acc_q, acc_d;
	logic [7:0]       low_q, low_d;
	logic [1:0]       cnt_q, cnt_d;

	assign step          = valid_s1 && free;
	assign payload.ready = !valid_s1 || free;
	assign accept        = payload.valid && payload.ready;
	assign stat.stage_valid = valid_s1;
	assign stat.step        = step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !free);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= payload.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsfp_pkg::PH_TAG;
			tag_q   <= '0;
			rem_q   <= '0;
			acc_q   <= 1'b0;
			low_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			rem_q   <= rem_d;
			acc_q   <= acc_d;
			low_q   <= low_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		rem_d     = rem_q;
		acc_d     = acc_q;
		low_d     = low_q;
		cnt_d     = cnt_q;
		res.valid = 1'b0;
		res.beat.setting_index = 3'(tag_q - 8'd1);
		res.beat.setting_value = {8'h00, data_s1.payload_byte};

		unique case (phase_q)
			tsfp_pkg::PH_LEN: begin
				rem_d   = data_s1.payload_byte;
				acc_d   = tsfp_pkg::field_is_valid(tag_q, data_s1.payload_byte);
				cnt_d   = '0;
				phase_d = (data_s1.payload_byte != 8'd0) ? tsfp_pkg::PH_VAL : tsfp_pkg::PH_TAG;
			end
			tsfp_pkg::PH_VAL: begin
				if (acc_q) begin
					if (tag_q <= tsfp_pkg::TAG_BYTE_HI) begin
						res.valid = 1'b1;
					end else if (cnt_q == 2'd0) begin
						low_d = data_s1.payload_byte;
					end else begin
						res.valid = 1'b1;
						res.beat.setting_value = {data_s1.payload_byte, low_q};
					end
				end
				cnt_d = cnt_q + 2'd1;
				rem_d = rem_q - 8'd1;
				if (rem_q == 8'd1) begin
					phase_d = tsfp_pkg::PH_TAG;
				end
			end
			default: begin
				// The unused phase code behaves as the tag phase.
				tag_d   = data_s1.payload_byte;
				phase_d = tsfp_pkg::PH_LEN;
			end
		endcase

		if (data_s1.last_byte) begin
			phase_d = tsfp_pkg::PH_TAG;
			tag_d   = '0;
			rem_d   = '0;
			acc_d   = 1'b0;
			low_d   = '0;
			cnt_d   = '0;
		end

		res.valid = res.valid && step;
	end

endmodule

`default_nettype wire

### hw/rtl/tsfp_out.sv
// ----------------------------------------------------------------------------
// tsfp_out
// Result register holding one update beat for the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfp_out (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tsfp_pkg::parse_res_t res,
	output logic                      free,
	tsfp_stream_if.source             update
);

	logic                valid_q;
	tsfp_pkg::out_beat_t data_q;

	// The register may load whenever it is empty or its beat leaves this cycle.
	assign free        = !valid_q || update.ready;
	assign update.valid = valid_q;
	assign update.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			data_q <= res.beat;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tlv_settings_field_parser_core.sv
// ----------------------------------------------------------------------------
// tlv_settings_field_parser_core
// Parses tag, length, value fields of a settings payload into setting updates.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Beat contents
//  payload   sink    payload_byte[7:0], last_byte
//  update    source  setting_index[2:0], setting_value[15:0]
//
//  One payload beat is taken per cycle while payload.ready is high; the update
//  of a valid field passes the input register, then the result register.
//  Reset clears the parse state to the tag phase and empties both registers.
//  A stall on update holds the result register, and the input register fills
//  behind it before payload.ready drops.
//
`default_nettype none

module tlv_settings_field_parser_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tsfp_stream_if.sink   payload,
	tsfp_stream_if.source update
);

	tsfp_pkg::parse_res_t  res;
	tsfp_pkg::parse_stat_t stat;
	logic                  free;

	tsfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.free    (free),
		.res     (res),
		.stat    (stat)
	);

	tsfp_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.free   (free),
		.update (update)
	);

	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> stat.step)
		else $error("update produced without a parse step");

	a_byte_setting_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.beat.setting_index[2]) |-> (res.beat.setting_value[15:8] == 8'h00))
		else $error("8-bit setting carries a non-zero upper byte");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(payload.valid && payload.ready) |=> stat.stage_valid)
		else $error("accepted beat did not reach the input register");

	a_update_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && free) |=> update.valid)
		else $error("update lost on its way to the result register");

endmodule

`default_nettype wire

### tb/tb_tlv_settings_field_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlv_settings_field_parser_core
// Self-checking bench for the TLV settings field parser.
// Byte-wide payloads are streamed in with random gaps and the setting updates
// are drained with random stalls. Each accepted byte drives a software copy of
// the parser. Each update is checked in order against the predicted updates.
// ----------------------------------------------------------------------------

module tb_tlv_settings_field_parser_core;

	localparam int STALL_LIMIT = 1000;
	localparam int LONG_HOLD   = 120;
	localparam int TAIL_CYCLES = 10;

	typedef struct {
		tsfp_pkg::in_beat_t beat;
		int                 gap;
		bit                 drain;
	} payload_item_t;

	logic clk = 1'b0;
	logic arst_n;

	tsfp_stream_if #(.beat_t(tsfp_pkg::in_beat_t))  payload_if ();
	tsfp_stream_if #(.beat_t(tsfp_pkg::out_beat_t)) update_if ();

	tlv_settings_field_parser_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(payload_if),
		.update (update_if)
	);

	always #5 clk = ~clk;

	payload_item_t       pending_payload[$];
	tsfp_pkg::out_beat_t expected_updates[$];

	// Software copy of the parser state
	tsfp_pkg::phase_t parse_state;
	logic [7:0]       field_tag;
	logic [7:0]       field_left;
	logic             field_ok;
	logic [7:0]       low_byte;
	logic [1:0]       value_count;

	int  gap_max      = 16;
	bit  drain_next   = 1'b0;
	bit  rx_idle_on   = 1'b1;
	bit  hold_request = 1'b0;
	int  beats_queued = 0;
	int  beats_taken  = 0;
	int  payloads_ended = 0;
	int  updates_checked = 0;
	int  word_updates = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  tx_wait;
	bit  tx_wait_drawn;
	int  rx_wait;
	int  rx_hold;
	payload_item_t tx_item;

	function void clear_parser();
		parse_state = tsfp_pkg::PH_TAG;
		field_tag   = '0;
		field_left  = '0;
		field_ok    = 1'b0;
		low_byte    = '0;
		value_count = '0;
	endfunction

	function void advance_parser(input tsfp_pkg::in_beat_t beat);
		tsfp_pkg::out_beat_t upd;
		logic [7:0]          b;
		b = beat.payload_byte;
		case (parse_state)
			tsfp_pkg::PH_LEN: begin
				field_left  = b;
				field_ok    = 1'b0;
				if (field_tag >= tsfp_pkg::TAG_BYTE_LO &&
						field_tag <= tsfp_pkg::TAG_BYTE_HI) begin
					field_ok = (b == tsfp_pkg::LEN_BYTE);
				end else if (field_tag >= tsfp_pkg::TAG_WORD_LO &&
						field_tag <= tsfp_pkg::TAG_WORD_HI) begin
					field_ok = (b == tsfp_pkg::LEN_WORD);
				end
				value_count = '0;
				parse_state = (b != 8'd0) ? tsfp_pkg::PH_VAL : tsfp_pkg::PH_TAG;
			end
			tsfp_pkg::PH_VAL: begin
				if (field_ok) begin
					upd.setting_index = field_tag[2:0] - 3'd1;
					if (field_tag <= tsfp_pkg::TAG_BYTE_HI) begin
						upd.setting_value = {8'h00, b};
						expected_updates.push_back(upd);
					end else if (value_count == 2'd0) begin
						low_byte = b;
					end else begin
						upd.setting_value = {b, low_byte};
						expected_updates.push_back(upd);
					end
				end
				value_count = value_count + 2'd1;
				field_left  = field_left - 8'd1;
				if (field_left == 8'd0) begin
					parse_state = tsfp_pkg::PH_TAG;
				end
			end
			default: begin
				field_tag   = b;
				parse_state = tsfp_pkg::PH_LEN;
			end
		endcase
		if (beat.last_byte) begin
			clear_parser();
		end
	endfunction

	function void flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endfunction

	function void check_update(input tsfp_pkg::out_beat_t got);
		tsfp_pkg::out_beat_t want;
		updates_checked++;
		if (got.setting_index >= 3'd4) begin
			word_updates++;
		end
		if (expected_updates.size() == 0) begin
			flag_error($sformatf("update with none pending: index %0d value 0x%04h",
				got.setting_index, got.setting_value));
		end else begin
			want = expected_updates.pop_front();
			if (got.setting_index !== want.setting_index ||
					got.setting_value !== want.setting_value) begin
				flag_error($sformatf(
					"update %0d: expected index %0d value 0x%04h, got index %0d value 0x%04h",
					updates_checked, want.setting_index, want.setting_value,
					got.setting_index, got.setting_value));
			end
		end
	endfunction

	task automatic queue_beat(input logic [7:0] value, input logic ends);
		payload_item_t item;
		item.beat.payload_byte = value;
		item.beat.last_byte    = ends;
		item.gap   = $urandom_range(0, gap_max);
		item.drain = drain_next;
		drain_next = 1'b0;
		pending_payload.push_back(item);
		beats_queued++;
	endtask

	// Queues the first 'keep' bytes of a field; the final queued byte carries
	// the end-of-payload flag when 'ends' is set.
	task automatic queue_field(input logic [7:0] tag, input logic [7:0] len,
			input int keep, input bit ends);
		int total;
		logic [7:0] b;
		total = int'(len) + 2;
		if (keep > total) begin
			keep = total;
		end
		for (int i = 0; i < keep; i++) begin
			b = (i == 0) ? tag : (i == 1) ? len : 8'($urandom);
			queue_beat(b, ends && (i == keep - 1));
		end
	endtask

	task automatic queue_random_bytes(input int count);
		int stop_at;
		int pick;
		logic [7:0] tag;
		logic [7:0] len;
		stop_at = beats_queued + count;
		while (beats_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			tag  = 8'($urandom_range(1, 8));
			len  = (tag <= tsfp_pkg::TAG_BYTE_HI) ? tsfp_pkg::LEN_BYTE : tsfp_pkg::LEN_WORD;
			if (pick < 60) begin
				queue_field(tag, len, int'(len) + 2, $urandom_range(0, 5) == 0);
			end else if (pick < 72) begin
				// Known tag that states the wrong length
				len = (8'($urandom_range(0, 4)) == len) ? 8'd0 : 8'($urandom_range(0, 4));
				if (len == ((tag <= tsfp_pkg::TAG_BYTE_HI) ?
						tsfp_pkg::LEN_BYTE : tsfp_pkg::LEN_WORD)) begin
					len = 8'd0;
				end
				queue_field(tag, len, int'(len) + 2, $urandom_range(0, 5) == 0);
			end else if (pick < 84) begin
				// Unknown tag; 256 folds onto tag zero
				tag = 8'($urandom_range(9, 256));
				len = ($urandom_range(0, 49) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
				queue_field(tag, len, int'(len) + 2, $urandom_range(0, 5) == 0);
			end else if (pick < 92) begin
				queue_beat(8'($urandom), $urandom_range(0, 3) == 0);
			end else begin
				// Payload ends before the field is complete
				queue_field(tag, len, $urandom_range(1, int'(len) + 1), 1'b1);
			end
		end
	endtask

	// Payload driver
	always @(posedge clk) begin
		if (!arst_n) begin
			payload_if.valid <= 1'b0;
			payload_if.data  <= '0;
			tx_wait = 0;
			tx_wait_drawn = 1'b0;
		end else if (!payload_if.valid || payload_if.ready) begin
			if (pending_payload.size() == 0) begin
				payload_if.valid <= 1'b0;
			end else begin
				if (!tx_wait_drawn) begin
					tx_wait = pending_payload[0].gap;
					tx_wait_drawn = 1'b1;
				end
				if (tx_wait > 0) begin
					tx_wait--;
					payload_if.valid <= 1'b0;
				end else if (pending_payload[0].drain &&
						(payload_if.valid || expected_updates.size() != 0)) begin
					// Hold back until every update owed so far has been taken.
					payload_if.valid <= 1'b0;
				end else begin
					tx_item = pending_payload.pop_front();
					payload_if.data  <= tx_item.beat;
					payload_if.valid <= 1'b1;
					tx_wait_drawn = 1'b0;
				end
			end
		end
	end

	// Update receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			update_if.ready <= 1'b0;
			rx_wait = 0;
			rx_hold = 0;
		end else begin
			if (update_if.valid && update_if.ready) begin
				rx_wait = rx_idle_on ? $urandom_range(0, 16) : 0;
			end
			if (hold_request) begin
				rx_hold = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				update_if.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				update_if.ready <= 1'b0;
			end else begin
				update_if.ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on each payload beat and checks each update beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (payload_if.valid && payload_if.ready) begin
				advance_parser(payload_if.data);
				beats_taken++;
				if (payload_if.data.last_byte) begin
					payloads_ended++;
				end
			end
			if (update_if.valid && update_if.ready) begin
				check_update(update_if.data);
			end
			if ((payload_if.valid && payload_if.ready) ||
					(update_if.valid && update_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("Timeout: no beat moved for %0d cycles, %0d updates outstanding",
			STALL_LIMIT, expected_updates.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		payload_if.valid = 1'b0;
		payload_if.data  = '0;
		update_if.ready  = 1'b0;
		clear_parser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Byte settings at the value extremes; the second ends its payload.
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h04, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'hFF, 1'b1);
		// Word settings, low byte first
		queue_beat(8'h05, 1'b0);
		queue_beat(8'h02, 1'b0);
		queue_beat(8'h34, 1'b0);
		queue_beat(8'h12, 1'b0);
		queue_beat(8'h08, 1'b0);
		queue_beat(8'h02, 1'b0);
		queue_beat(8'hFF, 1'b0);
		queue_beat(8'hFF, 1'b0);
		// Zero length: the following byte is a tag again
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h00, 1'b0);
		// Unknown tag, skipped by its length
		queue_beat(8'hFF, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'hA5, 1'b0);
		// Known tag with the wrong length
		queue_beat(8'h02, 1'b0);
		queue_beat(8'h02, 1'b0);
		queue_beat(8'h11, 1'b0);
		queue_beat(8'h22, 1'b0);
		// Word field cut short by the end of the payload
		queue_beat(8'h06, 1'b0);
		queue_beat(8'h02, 1'b0);
		queue_beat(8'h77, 1'b1);
		// Lone trailing byte
		queue_beat(8'h03, 1'b1);

		drain_next = 1'b1;
		queue_random_bytes(120);
		while (pending_payload.size() != 0) @(posedge clk);

		// Back-to-back traffic on both sides
		rx_idle_on = 1'b0;
		gap_max = 0;
		queue_random_bytes(80);
		while (pending_payload.size() != 0) @(posedge clk);

		// Long update stall while byte settings keep arriving
		hold_request = 1'b1;
		for (int i = 0; i < 20; i++) begin
			queue_field(8'($urandom_range(1, 4)), tsfp_pkg::LEN_BYTE, 3, 1'b0);
		end
		while (pending_payload.size() != 0) @(posedge clk);

		rx_idle_on = 1'b1;
		gap_max = 16;
		drain_next = 1'b1;
		queue_random_bytes(120);

		while (pending_payload.size() != 0 || payload_if.valid) @(posedge clk);
		while (expected_updates.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Streamed %0d payload bytes in %0d payloads; %0d updates checked, %0d 16-bit.",
			beats_taken, payloads_ended, updates_checked, word_updates);
		$display("Gaps, stalls, back-to-back traffic, a %0d-cycle update stall; %0d mismatches.",
			LONG_HOLD, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
